@@ rtl/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared constants and types of the text console glyph renderer: operation
// and character codes, register indexes, reset values and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

    localparam int CELL_WIDTH  = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DIM_W       = 13;
    localparam int COLOR_W     = 24;
    localparam int COORD_W     = 16;

    // operation codes
    localparam logic [1:0] OP_PUT_CHAR  = 2'd0;
    localparam logic [1:0] OP_LOAD_FONT = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;

    // control characters
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_RETURN    = 8'd13;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND    = 2'd3;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
    localparam logic [COLOR_W-1:0] FORE_RESET   = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BACK_RESET   = 24'h000000;

    // result kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef struct packed {
        logic capture;    // take the input item into the command register
        logic decode;     // act on the command: cursor, font write, row setup
        logic issue_row;  // read the next glyph row into the row stage
        logic issue_last; // that row ends the item
        logic push_fill;  // load a fill item into the output register
    } tcgr_cmd_t;

    typedef struct packed {
        logic glyph;      // command draws a glyph
        logic fill;       // command ends in a fill
        logic row_end;    // next row to issue is the final one
        logic a_valid;    // row stage holds a row
        logic a_free;     // row stage can take a row this cycle
        logic b_free;     // output register can take an item this cycle
    } tcgr_status_t;

endpackage

`default_nettype wire

@@ rtl/tcgr_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Controller of the glyph renderer: takes one item, has it decoded, then steps
// glyph rows one a cycle while the row stage is free, then a fill if needed.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_ctrl
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  tcgr_pkg::tcgr_status_t     st,
    output tcgr_pkg::tcgr_cmd_t        cmd
);
    import tcgr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_ROWS   = 2'd2;
    localparam logic [1:0] S_FILL   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       fill_after_reg;
    logic       fill_after_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        fill_after_next = fill_after_reg;
        cmd             = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (st.glyph)
                begin
                    fill_after_next = st.fill;
                    state_next      = S_ROWS;
                end
                else if (st.fill)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ROWS:
            begin
                if (st.a_free)
                begin
                    cmd.issue_row  = 1'b1;
                    cmd.issue_last = st.row_end && !fill_after_reg;
                    if (st.row_end)
                    begin
                        state_next = fill_after_reg ? S_FILL : S_IDLE;
                    end
                end
            end
            S_FILL:
            begin
                // wait for the rows ahead to leave the row stage and for the output to be free
                if (!st.a_valid && st.b_free)
                begin
                    cmd.push_fill = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_after_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_after_reg <= fill_after_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcgr_datapath.sv @@
// ----------------------------------------------------------------------------
// tcgr_datapath
// Datapath of the glyph renderer: configuration registers, cursor, glyph
// memory, the row stage behind the memory read and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_datapath
#(
    parameter int GLYPH_ROWS  = 13,
    parameter int LINE_HEIGHT = 14,
    parameter int LEFT_MARGIN = 8,
    parameter int TOP_MARGIN  = 8,
    parameter int GLYPH_COUNT = 256
)
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  tcgr_pkg::tcgr_cmd_t                            cmd,
    output tcgr_pkg::tcgr_status_t                         st,
    input  wire logic [1:0]                                in_operation,
    input  wire logic [7:0]                                in_character,
    input  wire logic [11:0]                               in_font_address,
    input  wire logic [7:0]                                in_font_byte,
    input  wire logic                                      cfg_we,
    input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  wire logic                                      out_ready,
    output logic                                           out_valid,
    output logic                                           out_kind,
    output logic [tcgr_pkg::COORD_W-1:0]                   out_x,
    output logic [tcgr_pkg::COORD_W-1:0]                   out_y,
    output logic [7:0]                                     out_bits,
    output logic [tcgr_pkg::COLOR_W-1:0]                   out_fore,
    output logic [tcgr_pkg::COLOR_W-1:0]                   out_back,
    output logic                                           out_last
);
    import tcgr_pkg::*;

    localparam int STORE_SIZE = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_W    = $clog2(STORE_SIZE);
    localparam int ROW_W      = $clog2(GLYPH_ROWS + 1);

    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(GLYPH_ROWS - 1);
    localparam logic [13:0]        STORE_LIM = 14'(STORE_SIZE);
    localparam logic [13:0]        ROWS14    = 14'(GLYPH_ROWS);
    localparam logic [8:0]         GC9       = 9'(GLYPH_COUNT);
    localparam logic [15:0]        CW16      = 16'(CELL_WIDTH);
    localparam logic [15:0]        LH16      = 16'(LINE_HEIGHT);
    localparam logic [16:0]        LH17      = 17'(LINE_HEIGHT);
    localparam logic [15:0]        LM16      = 16'(LEFT_MARGIN);
    localparam logic [15:0]        TM16      = 16'(TOP_MARGIN);
    localparam logic signed [17:0] TM18      = 18'(TOP_MARGIN);

    // configuration
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COLOR_W-1:0] fore_reg;
    logic [COLOR_W-1:0] back_reg;

    // command register
    logic [1:0]  op_reg;
    logic [7:0]  ch_reg;
    logic [11:0] fa_reg;
    logic [7:0]  fb_reg;

    // cursor
    logic [15:0] cursor_x_reg;
    logic [15:0] cursor_y_reg;
    logic [15:0] cursor_x_next;
    logic [15:0] cursor_y_next;

    // row issue
    logic [STORE_W-1:0] rd_addr_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [15:0]        glyph_x_reg;
    logic [15:0]        row_y_reg;

    // row stage
    logic        a_valid_reg;
    logic [7:0]  a_bits_reg;
    logic [15:0] a_x_reg;
    logic [15:0] a_y_reg;
    logic        a_last_reg;

    // output register
    logic        b_valid_reg;
    logic        b_kind_reg;
    logic [15:0] b_x_reg;
    logic [15:0] b_y_reg;
    logic [7:0]  b_bits_reg;
    logic [23:0] b_fore_reg;
    logic [23:0] b_back_reg;
    logic        b_last_reg;

    logic [7:0] glyph_mem [STORE_SIZE];

    // decode
    logic               is_nl;
    logic               is_cr;
    logic               is_bs;
    logic               is_glyph;
    logic [15:0]        x_step;
    logic [15:0]        y_step;
    logic [16:0]        y_below;
    logic               wrap;
    logic               wrap_fill;
    logic signed [17:0] nl_lhs;
    logic signed [17:0] nl_rhs;
    logic               nl_fill;
    logic [8:0]         code;
    logic [13:0]        base_addr;
    logic [13:0]        fa_ext;
    logic               font_we;
    logic               b_free;
    logic               b_load_row;

    always_comb
    begin
        is_nl     = (ch_reg == CHAR_NEWLINE);
        is_cr     = (ch_reg == CHAR_RETURN);
        is_bs     = (ch_reg == CHAR_BACKSPACE);
        is_glyph  = (op_reg == OP_PUT_CHAR) && !is_nl && !is_cr && !is_bs;
        x_step    = cursor_x_reg + CW16;
        y_step    = cursor_y_reg + LH16;
        y_below   = {1'b0, y_step} + LH17;
        wrap      = (x_step >= {3'b000, width_reg});
        wrap_fill = wrap && (y_below >= {4'b0000, height_reg});
        nl_lhs    = signed'({1'b0, y_below});
        nl_rhs    = signed'({5'b00000, height_reg}) - TM18;
        nl_fill   = (nl_lhs >= nl_rhs);
        // codes past the glyph count fold back onto the store
        code      = ({1'b0, ch_reg} >= GC9) ? ({1'b0, ch_reg} - GC9) : {1'b0, ch_reg};
        base_addr = {5'b00000, code} * ROWS14;
        fa_ext    = {2'b00, fa_reg};
        font_we   = cmd.decode && (op_reg == OP_LOAD_FONT) && (fa_ext < STORE_LIM);
    end

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.decode)
        begin
            unique case (op_reg)
                OP_PUT_CHAR:
                begin
                    if (is_nl)
                    begin
                        cursor_x_next = nl_fill ? LM16 : 16'd0;
                        cursor_y_next = nl_fill ? TM16 : y_step;
                    end
                    else if (is_cr)
                    begin
                        cursor_x_next = 16'd0;
                    end
                    else if (is_bs)
                    begin
                        if (cursor_x_reg >= CW16)
                        begin
                            cursor_x_next = cursor_x_reg - CW16;
                        end
                    end
                    else if (wrap)
                    begin
                        cursor_x_next = 16'd0;
                        cursor_y_next = wrap_fill ? 16'd0 : y_step;
                    end
                    else
                    begin
                        cursor_x_next = x_step;
                    end
                end
                OP_CLEAR:
                begin
                    cursor_x_next = LM16;
                    cursor_y_next = TM16;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign b_free     = !b_valid_reg || out_ready;
    assign b_load_row = a_valid_reg && b_free;

    always_comb
    begin
        st         = '0;
        st.glyph   = is_glyph;
        st.fill    = (op_reg == OP_CLEAR)
                   || ((op_reg == OP_PUT_CHAR) && is_nl && nl_fill)
                   || (is_glyph && wrap_fill);
        st.row_end = (row_reg == ROW_LAST);
        st.a_valid = a_valid_reg;
        st.a_free  = !a_valid_reg || b_free;
        st.b_free  = b_free;
    end

    // configuration and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            fore_reg     <= FORE_RESET;
            back_reg     <= BACK_RESET;
            cursor_x_reg <= LM16;
            cursor_y_reg <= TM16;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_SCREEN_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_FOREGROUND:    fore_reg   <= cfg_data[COLOR_W-1:0];
                    REG_BACKGROUND:    back_reg   <= cfg_data[COLOR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
        end
    end

    // command register and row setup
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_operation;
            ch_reg <= in_character;
            fa_reg <= in_font_address;
            fb_reg <= in_font_byte;
        end
        if (cmd.decode)
        begin
            rd_addr_reg <= base_addr[STORE_W-1:0];
            row_reg     <= '0;
            glyph_x_reg <= cursor_x_reg;
            row_y_reg   <= cursor_y_reg;
        end
        else if (cmd.issue_row)
        begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
            row_reg     <= row_reg + 1'b1;
            row_y_reg   <= row_y_reg + 16'd1;
        end
    end

    // glyph memory
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            glyph_mem[fa_ext[STORE_W-1:0]] <= fb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue_row)
        begin
            a_bits_reg <= glyph_mem[rd_addr_reg];
            a_x_reg    <= glyph_x_reg;
            a_y_reg    <= row_y_reg;
            a_last_reg <= cmd.issue_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.issue_row)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (b_load_row)
            begin
                a_valid_reg <= 1'b0;
            end
            if (b_load_row || cmd.push_fill)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // output register: a row from the row stage or a fill
    always_ff @(posedge clk)
    begin
        if (b_load_row)
        begin
            b_kind_reg <= KIND_ROW;
            b_x_reg    <= a_x_reg;
            b_y_reg    <= a_y_reg;
            b_bits_reg <= a_bits_reg;
            b_fore_reg <= fore_reg;
            b_back_reg <= back_reg;
            b_last_reg <= a_last_reg;
        end
        else if (cmd.push_fill)
        begin
            b_kind_reg <= KIND_FILL;
            b_x_reg    <= 16'd0;
            b_y_reg    <= 16'd0;
            b_bits_reg <= 8'd0;
            b_fore_reg <= fore_reg;
            b_back_reg <= back_reg;
            b_last_reg <= 1'b1;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_kind  = b_kind_reg;
    assign out_x     = b_x_reg;
    assign out_y     = b_y_reg;
    assign out_bits  = b_bits_reg;
    assign out_fore  = b_fore_reg;
    assign out_back  = b_back_reg;
    assign out_last  = b_last_reg;

endmodule

`default_nettype wire

@@ rtl/text_console_glyph_renderer_top.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console renderer: draws 8-pixel glyph rows from a loadable font store
// at a moving cursor, with line wrap, control codes and screen fills.
// ----------------------------------------------------------------------------
// One item is taken at a time. A printable character is accepted, then
// decoded as the cursor moves, then its glyph rows are read one a cycle
// from the glyph memory; a wrap past the bottom adds a trailing fill, which
// waits for the last row to leave the row stage. Font loads and control
// codes without a fill are only accepted and decoded; clear and a newline
// that runs off the bottom also push a fill. Results leave through an output
// register behind a one-row stage, so the next item is taken while earlier
// results still wait; a stalled output holds the row reads. The glyph
// store has no reset: rows must be loaded before the glyphs that use them
// are drawn.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_glyph_renderer_top
#(
    parameter int GLYPH_ROWS  = 13,
    parameter int LINE_HEIGHT = 14,
    parameter int LEFT_MARGIN = 8,
    parameter int TOP_MARGIN  = 8,
    parameter int GLYPH_COUNT = 256
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // character [7:0], font_address [19:8], font_byte [27:20], zero [31:28]
    input  wire logic [31:0]                       s_axis_tdata,
    // operation [1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // pixel_x [15:0], pixel_y [31:16], row_bits [39:32],
    // fore_value [63:40], back_value [87:64]
    output logic [87:0]                            m_axis_tdata,
    // kind [0]
    output logic [0:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [tcgr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tcgr_pkg::*;

    tcgr_cmd_t    cmd;
    tcgr_status_t st;

    logic         out_kind;
    logic [15:0]  out_x;
    logic [15:0]  out_y;
    logic [7:0]   out_bits;
    logic [23:0]  out_fore;
    logic [23:0]  out_back;

    tcgr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    tcgr_datapath
    #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .LINE_HEIGHT (LINE_HEIGHT),
        .LEFT_MARGIN (LEFT_MARGIN),
        .TOP_MARGIN  (TOP_MARGIN),
        .GLYPH_COUNT (GLYPH_COUNT)
    )
    u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .in_operation    (s_axis_tuser),
        .in_character    (s_axis_tdata[7:0]),
        .in_font_address (s_axis_tdata[19:8]),
        .in_font_byte    (s_axis_tdata[27:20]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_kind        (out_kind),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_bits        (out_bits),
        .out_fore        (out_fore),
        .out_back        (out_back),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {out_back, out_fore, out_bits, out_y, out_x};
    assign m_axis_tuser = out_kind;

    // a fill always closes the item that caused it
    a_fill_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[0] == KIND_FILL)) |-> m_axis_tlast)
        else $error("fill item without tlast");

    // the row stage and the fill never load the output in the same cycle
    a_fill_row_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_fill |-> !st.a_valid && !cmd.issue_row)
        else $error("fill pushed while a row is in flight");

    // an accepted item is decoded before another is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready && cmd.decode)
        else $error("input taken again before decode");

endmodule

`default_nettype wire

@@ verif/tb_text_console_glyph_renderer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_glyph_renderer_top
// Self-checking bench for the text console glyph renderer. Loads glyphs,
// walks the control codes, screen-edge wraps and fills, runs random traffic
// under three idling regimes; every row write and fill is predicted from a
// local copy of the cursor, font store and registers and checked in order.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_top;

    import tcgr_pkg::*;

    localparam int GLYPH_ROWS    = 13;
    localparam int LINE_HEIGHT   = 14;
    localparam int LEFT_MARGIN   = 8;
    localparam int TOP_MARGIN    = 8;
    localparam int GLYPH_COUNT   = 256;
    localparam int STORE_SIZE    = GLYPH_COUNT * GLYPH_ROWS;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 40;
    localparam int RANDOM_ITEMS  = 45;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  row_bits;
        logic [23:0] fore;
        logic [23:0] back;
        logic        last;
    } draw_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    logic [DIM_W-1:0]   scr_width;
    logic [DIM_W-1:0]   scr_height;
    logic [COLOR_W-1:0] pred_fore;
    logic [COLOR_W-1:0] pred_back;
    logic [15:0]        cur_x;
    logic [15:0]        cur_y;
    logic [7:0]         glyph_rom [STORE_SIZE];
    int                 ready_codes [$];
    draw_t              expected_draws [$];

    int error_count;
    int cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    text_console_glyph_renderer_top
    #(
        .GLYPH_ROWS  (GLYPH_ROWS),
        .LINE_HEIGHT (LINE_HEIGHT),
        .LEFT_MARGIN (LEFT_MARGIN),
        .TOP_MARGIN  (TOP_MARGIN),
        .GLYPH_COUNT (GLYPH_COUNT)
    )
    uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic push_fill();
        draw_t d;
        d = '{kind: KIND_FILL, px: '0, py: '0, row_bits: '0,
              fore: pred_fore, back: pred_back, last: 1'b1};
        expected_draws.push_back(d);
    endtask

    task automatic render_glyph(input logic [7:0] ch);
        int          code;
        logic [15:0] x0;
        logic [15:0] y0;
        logic        fill;
        draw_t       d;
        code = ch;
        if (code >= GLYPH_COUNT)
            code -= GLYPH_COUNT;
        x0   = cur_x;
        y0   = cur_y;
        fill = 1'b0;
        cur_x = cur_x + 16'(CELL_WIDTH);
        if (cur_x >= scr_width)
        begin
            cur_x = '0;
            cur_y = cur_y + 16'(LINE_HEIGHT);
            if (int'(cur_y) + LINE_HEIGHT >= int'(scr_height))
            begin
                fill  = 1'b1;
                cur_x = '0;
                cur_y = '0;
            end
        end
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            d = '{kind: KIND_ROW, px: x0, py: y0 + 16'(r),
                  row_bits: glyph_rom[code * GLYPH_ROWS + r],
                  fore: pred_fore, back: pred_back,
                  last: (r == GLYPH_ROWS - 1) && !fill};
            expected_draws.push_back(d);
        end
        if (fill)
            push_fill();
    endtask

    task automatic trace_console_item(input logic [1:0] op, input logic [7:0] ch,
                                      input logic [11:0] addr, input logic [7:0] fb);
        case (op)
            OP_PUT_CHAR:
            begin
                if (ch == CHAR_NEWLINE)
                begin
                    cur_x = '0;
                    cur_y = cur_y + 16'(LINE_HEIGHT);
                    // signed compare against the height less the top margin
                    if (int'(cur_y) + LINE_HEIGHT >= int'(scr_height) - TOP_MARGIN)
                    begin
                        push_fill();
                        cur_x = 16'(LEFT_MARGIN);
                        cur_y = 16'(TOP_MARGIN);
                    end
                end
                else if (ch == CHAR_RETURN)
                    cur_x = '0;
                else if (ch == CHAR_BACKSPACE)
                begin
                    if (cur_x >= 16'(CELL_WIDTH))
                        cur_x = cur_x - 16'(CELL_WIDTH);
                end
                else
                    render_glyph(ch);
            end
            OP_LOAD_FONT:
            begin
                if (addr < STORE_SIZE)
                begin
                    glyph_rom[addr] = fb;
                end
            end
            OP_CLEAR:
            begin
                push_fill();
                cur_x = 16'(LEFT_MARGIN);
                cur_y = 16'(TOP_MARGIN);
            end
            default:
            begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input logic [11:0] addr, input logic [7:0] fb);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, fb, addr, ch};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        trace_console_item(op, ch, addr, fb);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_item(OP_PUT_CHAR, ch, 12'($urandom), 8'($urandom));
    endtask

    task automatic load_font(input logic [11:0] addr, input logic [7:0] fb);
        send_item(OP_LOAD_FONT, 8'($urandom), addr, fb);
    endtask

    task automatic clear_screen();
        send_item(OP_CLEAR, 8'($urandom), 12'($urandom), 8'($urandom));
    endtask

    task automatic load_glyph(input int code);
        for (int r = 0; r < GLYPH_ROWS; r++)
            load_font(12'(code * GLYPH_ROWS + r), 8'($urandom));
        ready_codes.push_back(code);
    endtask

    // drop valid, let every expected result arrive, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_index <= REG_FOREGROUND;
        cfg_data  <= fg;
        @(posedge clk);
        cfg_index <= REG_BACKGROUND;
        cfg_data  <= bg;
        @(posedge clk);
        cfg_we <= 1'b0;
        scr_width  = w;
        scr_height = h;
        pred_fore  = fg;
        pred_back  = bg;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        if (error_count < MAX_REPORTS)
            $display("ERROR at %0d ns: %s: got %0h, expected %0h",
                     $time, what, got_v, want_v);
        error_count++;
    endtask

    task automatic check_draw();
        draw_t got;
        draw_t want;
        got = '{kind: m_axis_tuser[0], px: m_axis_tdata[15:0], py: m_axis_tdata[31:16],
                row_bits: m_axis_tdata[39:32], fore: m_axis_tdata[63:40],
                back: m_axis_tdata[87:64], last: m_axis_tlast};
        if (expected_draws.size() == 0)
        begin
            report_mismatch("result with nothing expected, pixel_y", got.py, 0);
            return;
        end
        want = expected_draws.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", got.kind, want.kind);
        if (got.px !== want.px)
            report_mismatch("pixel_x", got.px, want.px);
        if (got.py !== want.py)
            report_mismatch("pixel_y", got.py, want.py);
        if (got.row_bits !== want.row_bits)
            report_mismatch("row_bits", got.row_bits, want.row_bits);
        if (got.fore !== want.fore)
            report_mismatch("fore_value", got.fore, want.fore);
        if (got.back !== want.back)
            report_mismatch("back_value", got.back, want.back);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_draw();
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_font_load();
        // lowest and highest store entries, all-zero and all-one rows
        load_font(12'd0, 8'h00);
        for (int r = 1; r < GLYPH_ROWS; r++)
            load_font(12'(r), 8'($urandom));
        ready_codes.push_back(0);
        load_glyph(8'h41);
        for (int r = 0; r < GLYPH_ROWS - 1; r++)
            load_font(12'(255 * GLYPH_ROWS + r), 8'($urandom));
        load_font(12'(STORE_SIZE - 1), 8'hFF);
        ready_codes.push_back(255);
    endtask

    task automatic test_control_codes();
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CHAR_BACKSPACE);
        put_char(CHAR_RETURN);
        put_char(CHAR_BACKSPACE);  // already at the left edge: hold
        put_char(8'h41);
        put_char(CHAR_NEWLINE);
        send_item(OP_UNUSED, 8'hFF, 12'hFFF, 8'hFF);
        load_font(12'hFFF, 8'hFF);  // beyond the store: drop
        load_font(12'(STORE_SIZE), 8'h5A);
        load_font(12'd0, 8'hFF);
        put_char(8'h00);
        clear_screen();
        put_char(8'hFF);
        put_char(CHAR_NEWLINE);
    endtask

    task automatic test_screen_edges();
        // narrowest screen: glyphs wrap and every wrap runs off the bottom
        set_screen(13'd16, 13'd16, 24'h000000, 24'hFFFFFF);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(CHAR_NEWLINE);
        put_char(8'h00);
        put_char(CHAR_BACKSPACE);
        put_char(CHAR_NEWLINE);
        put_char(8'h41);
        // widest screen
        set_screen(13'd4096, 13'd4096, 24'hFFFFFF, 24'h000000);
        put_char(8'h41);
        put_char(CHAR_NEWLINE);
        put_char(8'hFF);
        put_char(CHAR_RETURN);
        put_char(8'h00);
        clear_screen();
        put_char(8'h41);
    endtask

    task automatic test_random_traffic(input int n_items);
        int code;
        int pick;
        set_screen(13'($urandom_range(16, 240)), 13'($urandom_range(16, 200)),
                   24'($urandom), 24'($urandom));
        do
            code = $urandom_range(0, GLYPH_COUNT - 1);
        while (code inside {ready_codes});
        load_glyph(code);
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                put_char(8'(ready_codes[$urandom_range(0, ready_codes.size() - 1)]));
            else if (pick < 65)
                put_char(CHAR_NEWLINE);
            else if (pick < 70)
                put_char(CHAR_RETURN);
            else if (pick < 76)
                put_char(CHAR_BACKSPACE);
            else if (pick < 81)
                clear_screen();
            else if (pick < 91)
            begin
                // rewrite a row of a glyph already in use
                code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
                load_font(12'(code * GLYPH_ROWS + $urandom_range(0, GLYPH_ROWS - 1)),
                          8'($urandom));
            end
            else if (pick < 96)
                load_font(12'($urandom_range(STORE_SIZE, 4095)), 8'($urandom));
            else
                send_item(OP_UNUSED, 8'($urandom), 12'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 23;
        recv_idle_pct = 85;
        scr_width     = WIDTH_RESET;
        scr_height    = HEIGHT_RESET;
        pred_fore     = FORE_RESET;
        pred_back     = BACK_RESET;
        cur_x         = 16'(LEFT_MARGIN);
        cur_y         = 16'(TOP_MARGIN);
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUT_CHAR;
        m_axis_tready <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_SCREEN_WIDTH;
        cfg_data      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_font_load();
        test_control_codes();
        test_random_traffic(RANDOM_ITEMS);

        wait_idle();
        send_idle_pct = 85;
        recv_idle_pct = 23;
        test_screen_edges();
        test_random_traffic(RANDOM_ITEMS);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(RANDOM_ITEMS);

        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tcgr_pkg.sv
rtl/tcgr_ctrl.sv
rtl/tcgr_datapath.sv
rtl/text_console_glyph_renderer_top.sv
verif/tb_text_console_glyph_renderer_top.sv
